/* design/urxf_pkg.sv */
// urxf_pkg: shared constants, codes and types for the UART receive FIFO block.
// No dependencies; compile first.
package urxf_pkg;

  localparam int Depth   = 128;
  localparam int PtrW    = $clog2(Depth);
  localparam int CntW    = $clog2(Depth + 1);
  localparam int LevelW  = 9;
  localparam int ByteW   = 8;
  localparam int CfgIdxW = 1;

  typedef enum logic [1:0] {
    MODE_RX       = 2'd0,
    MODE_READ     = 2'd1,
    MODE_TX_DONE  = 2'd2,
    MODE_TX_WRITE = 2'd3
  } mode_e;

  localparam logic [CfgIdxW-1:0] REG_PAUSE  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RESUME = 1'b1;

  localparam logic [LevelW-1:0] PauseRst  = 9'd32;
  localparam logic [LevelW-1:0] ResumeRst = 9'd64;

endpackage

/* design/urxf_if.sv */
// Handshake channels of the UART receive FIFO: input words, result words, config writes.
// Depends on urxf_pkg.
interface urxf_in_if;
  logic                         valid;
  logic                         ready;
  urxf_pkg::mode_e              mode;
  logic [urxf_pkg::ByteW-1:0]   rx_byte;
  logic [urxf_pkg::ByteW-1:0]   tx_byte;

  modport source (output valid, mode, rx_byte, tx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, tx_byte, output ready);
endinterface

interface urxf_out_if;
  logic                         valid;
  logic                         ready;
  logic [urxf_pkg::ByteW-1:0]   read_data;
  logic                         read_valid;
  logic                         rts_out;
  logic                         char_available;
  logic [urxf_pkg::LevelW-1:0]  free_space;
  logic                         overflow;
  logic                         transmit_ready;
  logic                         transmit_start;
  logic [urxf_pkg::ByteW-1:0]   transmit_data;

  modport source (output valid, read_data, read_valid, rts_out, char_available, free_space,
                  overflow, transmit_ready, transmit_start, transmit_data, input ready);
  modport sink   (input valid, read_data, read_valid, rts_out, char_available, free_space,
                  overflow, transmit_ready, transmit_start, transmit_data, output ready);
endinterface

interface urxf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [urxf_pkg::CfgIdxW-1:0]  index;
  logic [urxf_pkg::LevelW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/urxf_ram.sv */
// urxf_ram: simple dual-port synchronous RAM, one write and one registered read port.
// No package dependency.
module urxf_ram #(
  parameter int DataW = 8,
  parameter int AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/uart_rx_fifo_rts_flow_control.sv */
// uart_rx_fifo_rts_flow_control: receive byte FIFO with RTS hysteresis and transmit-ready flag.
// Depends on urxf_pkg, urxf_if.sv (channel interfaces) and urxf_ram.
//
//   channel | dir | payload                                      | handshake
//   --------+-----+----------------------------------------------+-------------
//   in_i    | in  | mode, rx_byte, tx_byte                       | valid/ready
//   out_o   | out | read_data, read_valid, rts_out, ...          | valid/ready
//   cfg_i   | in  | index (0 pause, 1 resume), data (9 bit)      | valid/ready
//
// One result word per input word. Receive, transmit-done and transmit-write words and a read
// of an empty FIFO have their result registered in the cycle after acceptance; a read that
// pops passes through the FIFO RAM read register and then the result register.
// Input is taken with no pop pending and the output empty or drained in the same cycle.
// Reset (rst_ni low, async) empties the FIFO, lowers RTS, sets transmit ready and loads the
// default levels 32/64. RAM contents are not cleared; a pop only reads written entries.
// cfg_i is always ready; writes are expected only while the block is idle.
module uart_rx_fifo_rts_flow_control (
  input  logic       clk_i,
  input  logic       rst_ni,
  urxf_in_if.sink    in_i,
  urxf_out_if.source out_o,
  urxf_cfg_if.sink   cfg_i
);

  typedef struct packed {
    logic [urxf_pkg::ByteW-1:0]  read_data;
    logic                        read_valid;
    logic                        rts_out;
    logic                        char_available;
    logic [urxf_pkg::LevelW-1:0] free_space;
    logic                        overflow;
    logic                        transmit_ready;
    logic                        transmit_start;
    logic [urxf_pkg::ByteW-1:0]  transmit_data;
  } out_word_t;

  // sequencer: idle, or waiting for RAM read data
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;

  logic [urxf_pkg::PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [urxf_pkg::PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [urxf_pkg::CntW-1:0]   space_q, space_d;
  logic                        rts_q, rts_d;
  logic                        tx_rdy_q, tx_rdy_d;
  logic [urxf_pkg::LevelW-1:0] pause_q, resume_q;

  out_word_t word_q, word_d;
  logic      out_valid_q, out_valid_d;

  logic                       in_ready, in_fire;
  logic                       ram_we, ram_re;
  logic [urxf_pkg::ByteW-1:0] ram_rdata;

  localparam logic [urxf_pkg::CntW-1:0] DepthCnt = urxf_pkg::CntW'(urxf_pkg::Depth);

  // ------------------------------------------------------------------
  // handshakes
  // ------------------------------------------------------------------
  assign in_ready   = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;

  // ------------------------------------------------------------------
  // FIFO storage
  // ------------------------------------------------------------------
  // Writes happen on the accept edge of a receive word; a pop reads on the
  // accept edge of its own word, so write and read never overlap in time.
  urxf_ram #(
    .DataW (urxf_pkg::ByteW),
    .AddrW (urxf_pkg::PtrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------
  // next-state and result word
  // ------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    space_d     = space_q;
    rts_d       = rts_q;
    tx_rdy_d    = tx_rdy_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (state_q == S_READ) begin
      // popped byte arrives; rest of the word was filled at accept
      word_d.read_data = ram_rdata;
      out_valid_d      = 1'b1;
      state_d          = S_IDLE;
    end else if (in_fire) begin
      word_d = '0;
      unique case (in_i.mode)
        urxf_pkg::MODE_RX: begin
          if (space_q == '0) begin
            // full: drop the byte, RTS left alone
            word_d.overflow = 1'b1;
          end else begin
            ram_we   = 1'b1;
            wr_ptr_d = wr_ptr_q + 1'b1;
            space_d  = space_q - 1'b1;
            if (!rts_q && (urxf_pkg::LevelW'(space_d) < pause_q)) begin
              rts_d = 1'b1;
            end
          end
        end
        urxf_pkg::MODE_READ: begin
          if (space_q != DepthCnt) begin
            ram_re            = 1'b1;
            word_d.read_valid = 1'b1;
            rd_ptr_d          = rd_ptr_q + 1'b1;
            space_d           = space_q + 1'b1;
            if (rts_q && (urxf_pkg::LevelW'(space_d) > resume_q)) begin
              rts_d = 1'b0;
            end
            state_d = S_READ;
          end
        end
        urxf_pkg::MODE_TX_DONE: begin
          tx_rdy_d = 1'b1;
        end
        urxf_pkg::MODE_TX_WRITE: begin
          if (tx_rdy_q) begin
            word_d.transmit_start = 1'b1;
            word_d.transmit_data  = in_i.tx_byte;
            tx_rdy_d              = 1'b0;
          end
        end
        default: begin
        end
      endcase
      word_d.rts_out        = rts_d;
      word_d.char_available = (space_d != DepthCnt);
      word_d.free_space     = urxf_pkg::LevelW'(space_d);
      word_d.transmit_ready = tx_rdy_d;
      out_valid_d           = (state_d != S_READ);
    end
  end

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      space_q     <= DepthCnt;
      rts_q       <= 1'b0;
      tx_rdy_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      space_q     <= space_d;
      rts_q       <= rts_d;
      tx_rdy_q    <= tx_rdy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q  <= urxf_pkg::PauseRst;
      resume_q <= urxf_pkg::ResumeRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        urxf_pkg::REG_PAUSE:  pause_q  <= cfg_i.data;
        urxf_pkg::REG_RESUME: resume_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // ------------------------------------------------------------------
  // outputs
  // ------------------------------------------------------------------
  assign out_o.valid          = out_valid_q;
  assign out_o.read_data      = word_q.read_data;
  assign out_o.read_valid     = word_q.read_valid;
  assign out_o.rts_out        = word_q.rts_out;
  assign out_o.char_available = word_q.char_available;
  assign out_o.free_space     = word_q.free_space;
  assign out_o.overflow       = word_q.overflow;
  assign out_o.transmit_ready = word_q.transmit_ready;
  assign out_o.transmit_start = word_q.transmit_start;
  assign out_o.transmit_data  = word_q.transmit_data;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  a_space_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    space_q <= DepthCnt)
    else $error("free space count above FIFO depth");

  a_ptr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == urxf_pkg::PtrW'(DepthCnt - space_q))
    else $error("pointer distance disagrees with free space count");

  a_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (!out_valid_q && !in_ready))
    else $error("result slot busy while pop data is pending");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (out_valid_q && word_q.read_valid))
    else $error("pop did not yield a valid read word");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && word_q.overflow) |-> (word_q.free_space == '0))
    else $error("overflow flagged with free space left");

endmodule
